/* src/ptb_pkg.sv */
// ----------------------------------------------------------------------------
// ptb_pkg
// Shared types and constants of the page table builder.
// ----------------------------------------------------------------------------
package ptb_pkg;

    localparam int TABLE_PAGES = 64;                 // pool size, power of two
    localparam int PAGE_W      = $clog2(TABLE_PAGES);
    localparam int SLOT_W      = 9;                  // 512 entries per table page
    localparam int MEM_AW      = PAGE_W + SLOT_W;
    localparam int MEM_DEPTH   = TABLE_PAGES * (1 << SLOT_W);
    localparam int CNT_W       = 7;                  // width of tables_used

    localparam logic [63:0] ADDR_MASK   = 64'h000F_FFFF_FFFF_F000;
    localparam logic [63:0] BIT_PRESENT = 64'h1;
    localparam logic [11:0] LINK_FLAGS  = 12'h003;   // present and writable

    localparam logic [1:0] ACT_MAP    = 2'd0;
    localparam logic [1:0] ACT_ALIAS  = 2'd1;
    localparam logic [1:0] ACT_MODIFY = 2'd2;

    localparam logic [1:0] SIZE_4K = 2'd0;
    localparam logic [1:0] SIZE_2M = 2'd1;

    localparam logic REG_POOL_BASE = 1'b0;

    typedef struct packed {
        logic [1:0]  action;
        logic [47:0] target_addr;
        logic [47:0] dest_addr;
        logic [51:0] frame_addr;
        logic [63:0] set_flags;
        logic [63:0] clear_flags;
        logic        keep_existing;
        logic [1:0]  level_size;
    } req_t;

    typedef struct packed {
        logic             written;
        logic             status;
        logic [CNT_W-1:0] tables_used;
    } res_t;

endpackage

/* src/ptb_if.sv */
// ----------------------------------------------------------------------------
// ptb_req_if / ptb_res_if
// Valid/ready channels for request and result beats.
// ----------------------------------------------------------------------------
interface ptb_req_if;
    import ptb_pkg::*;
    logic valid;
    logic ready;
    req_t payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface ptb_res_if;
    import ptb_pkg::*;
    logic valid;
    logic ready;
    res_t payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

/* src/ptb_table_mem.sv */
// ----------------------------------------------------------------------------
// ptb_table_mem
// Single-port table store, one access per cycle, registered read data.
// ----------------------------------------------------------------------------
module ptb_table_mem (
    input  logic                      clk,
    input  logic                      we,
    input  logic [ptb_pkg::MEM_AW-1:0] addr,
    input  logic [63:0]               wdata,
    output logic [63:0]               rdata
);
    import ptb_pkg::*;

    logic [63:0] mem_q [MEM_DEPTH];
    logic [63:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_q[addr] <= wdata;
        end
        rdata_reg <= mem_q[addr];
    end

    assign rdata = rdata_reg;

endmodule

/* src/page_table_builder.sv */
// ----------------------------------------------------------------------------
// page_table_builder
// Four-level x86-64 page table builder over an internal pool of table pages.
// ----------------------------------------------------------------------------
// One request is handled at a time. After reset the block sweeps the whole
// table store to zero, one entry a cycle, and takes no request until that is
// done; configuration writes are taken throughout. A request then reads and
// inspects the returned entry at each directory level walked, reads and acts
// on the leaf, and hands over the result; an alias walks twice. Each table
// page allocated on the way is cleared, all 512 of its entries, and is then
// linked from its parent entry. The single port of the table store sets the
// pace: every walk step is one dependent read. The result sits in an output
// register, so the next request is taken while it waits.
// ----------------------------------------------------------------------------
module page_table_builder (
    input  logic        clk,
    input  logic        rst_n,
    ptb_req_if.sink     req,
    ptb_res_if.source   res,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import ptb_pkg::*;

    localparam logic [2:0] ST_INIT = 3'd0;   // reset sweep of the store
    localparam logic [2:0] ST_IDLE = 3'd1;
    localparam logic [2:0] ST_RD   = 3'd2;   // issue read of current entry
    localparam logic [2:0] ST_CHK  = 3'd3;   // inspect a directory entry
    localparam logic [2:0] ST_CLR  = 3'd4;   // clear a new table page
    localparam logic [2:0] ST_LINK = 3'd5;   // write link to the new page
    localparam logic [2:0] ST_LEAF = 3'd6;   // act on the leaf entry
    localparam logic [2:0] ST_DONE = 3'd7;   // hand the result over

    logic [2:0]        state_reg, state_next;
    req_t              req_reg, req_next;
    logic              phase_reg, phase_next;      // alias: 0 source, 1 target
    logic [PAGE_W-1:0] page_reg, page_next;
    logic [1:0]        lvl_reg, lvl_next;
    logic [PAGE_W-1:0] new_page_reg, new_page_next;
    logic [MEM_AW-1:0] sweep_reg, sweep_next;
    logic [CNT_W-1:0]  nfp_reg, nfp_next;
    logic [63:0]       val_reg, val_next;
    logic              written_reg, written_next;
    logic              status_reg, status_next;
    logic              res_valid_reg, res_valid_next;
    res_t              res_reg, res_next;
    logic [7:0]        base_reg, base_next;

    logic              mem_we;
    logic [MEM_AW-1:0] mem_addr;
    logic [63:0]       mem_wdata;
    logic [63:0]       mem_rdata;

    logic [47:0]       walk_addr;
    logic [SLOT_W-1:0] slot;
    logic [1:0]        leaf_lvl;
    logic              create;
    logic [7:0]        num;
    logic [7:0]        diff;
    logic [7:0]        link_num;
    logic              cfg_wr;

    ptb_table_mem u_mem (
        .clk   (clk),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    // APB: one register, pool_base_page, at byte address 0
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign prdata = (paddr[2] == REG_POOL_BASE) ? {24'b0, base_reg} : 32'b0;

    always_comb
    begin
        base_next = base_reg;
        if (cfg_wr && paddr[2] == REG_POOL_BASE)
        begin
            base_next = pwdata[7:0];
        end
    end

    // walk context
    assign walk_addr = phase_reg ? req_reg.dest_addr : req_reg.target_addr;
    assign create    = (req_reg.action == ACT_MAP) || phase_reg;

    always_comb
    begin
        case (lvl_reg)
            2'd0:    slot = walk_addr[47:39];
            2'd1:    slot = walk_addr[38:30];
            2'd2:    slot = walk_addr[29:21];
            default: slot = walk_addr[20:12];
        endcase
    end

    always_comb
    begin
        if (req_reg.action != ACT_MAP)
        begin
            leaf_lvl = 2'd3;
        end
        else
        begin
            case (req_reg.level_size)
                SIZE_4K: leaf_lvl = 2'd3;
                SIZE_2M: leaf_lvl = 2'd2;
                default: leaf_lvl = 2'd1;   // 1GB, and the unused code
            endcase
        end
    end

    assign num      = mem_rdata[19:12];
    assign diff     = num - base_reg;
    assign link_num = base_reg + 8'(new_page_reg);

    assign req.ready = (state_reg == ST_IDLE);
    assign res.valid = res_valid_reg;
    assign res.payload = res_reg;

    always_comb
    begin
        state_next     = state_reg;
        req_next       = req_reg;
        phase_next     = phase_reg;
        page_next      = page_reg;
        lvl_next       = lvl_reg;
        new_page_next  = new_page_reg;
        sweep_next     = sweep_reg;
        nfp_next       = nfp_reg;
        val_next       = val_reg;
        written_next   = written_reg;
        status_next    = status_reg;
        res_valid_next = res_valid_reg;
        res_next       = res_reg;
        mem_we         = 1'b0;
        mem_addr       = {page_reg, slot};
        mem_wdata      = 64'b0;

        // drop the result once taken
        if (res_valid_reg && res.ready)
        begin
            res_valid_next = 1'b0;
        end

        case (state_reg)
            ST_INIT:
            begin
                mem_we     = 1'b1;
                mem_addr   = sweep_reg;
                sweep_next = sweep_reg + 1'b1;
                if (sweep_reg == {MEM_AW{1'b1}})
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    req_next     = req.payload;
                    phase_next   = 1'b0;
                    page_next    = '0;
                    lvl_next     = 2'd0;
                    written_next = 1'b0;
                    status_next  = 1'b0;
                    if (req.payload.action inside {ACT_MAP, ACT_ALIAS, ACT_MODIFY})
                    begin
                        state_next = ST_RD;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_RD:
            begin
                state_next = (lvl_reg == leaf_lvl) ? ST_LEAF : ST_CHK;
            end
            ST_CHK:
            begin
                if (num != 8'd0)
                begin
                    // follow the link, foreign or not
                    page_next  = PAGE_W'(diff % TABLE_PAGES);
                    lvl_next   = lvl_reg + 1'b1;
                    state_next = ST_RD;
                end
                else if (!create)
                begin
                    if (req_reg.action == ACT_ALIAS)
                    begin
                        // source missing: flags only, no present, no address
                        val_next   = req_reg.set_flags & ~(BIT_PRESENT | ADDR_MASK);
                        phase_next = 1'b1;
                        page_next  = '0;
                        lvl_next   = 2'd0;
                        state_next = ST_RD;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
                else if (nfp_reg >= CNT_W'(TABLE_PAGES))
                begin
                    status_next = 1'b1;
                    state_next  = ST_DONE;
                end
                else
                begin
                    new_page_next = nfp_reg[PAGE_W-1:0];
                    nfp_next      = nfp_reg + 1'b1;
                    sweep_next    = '0;
                    state_next    = ST_CLR;
                end
            end
            ST_CLR:
            begin
                mem_we     = 1'b1;
                mem_addr   = {new_page_reg, sweep_reg[SLOT_W-1:0]};
                sweep_next = sweep_reg + 1'b1;
                if (sweep_reg[SLOT_W-1:0] == {SLOT_W{1'b1}})
                begin
                    state_next = ST_LINK;
                end
            end
            ST_LINK:
            begin
                mem_we     = 1'b1;
                mem_wdata  = {44'b0, link_num, LINK_FLAGS};
                page_next  = new_page_reg;
                lvl_next   = lvl_reg + 1'b1;
                state_next = ST_RD;
            end
            ST_LEAF:
            begin
                state_next = ST_DONE;
                if (req_reg.action == ACT_MAP)
                begin
                    if (!(req_reg.keep_existing && (mem_rdata & ADDR_MASK) != 64'b0))
                    begin
                        mem_we       = 1'b1;
                        mem_wdata    = 64'(req_reg.frame_addr) | req_reg.set_flags;
                        written_next = 1'b1;
                    end
                end
                else if (req_reg.action == ACT_ALIAS)
                begin
                    if (!phase_reg)
                    begin
                        val_next   = (mem_rdata & ADDR_MASK) | req_reg.set_flags;
                        phase_next = 1'b1;
                        page_next  = '0;
                        lvl_next   = 2'd0;
                        state_next = ST_RD;
                    end
                    else
                    begin
                        mem_we       = 1'b1;
                        mem_wdata    = val_reg;
                        written_next = 1'b1;
                    end
                end
                else
                begin
                    mem_we       = 1'b1;
                    mem_wdata    = (mem_rdata & ~req_reg.clear_flags) | req_reg.set_flags;
                    written_next = 1'b1;
                end
            end
            ST_DONE:
            begin
                // hold until the output register is free
                if (!res_valid_reg || res.ready)
                begin
                    res_valid_next       = 1'b1;
                    res_next.written     = written_reg;
                    res_next.status      = status_reg;
                    res_next.tables_used = nfp_reg;
                    state_next           = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT;
            sweep_reg     <= '0;
            nfp_reg       <= CNT_W'(1);
            res_valid_reg <= 1'b0;
            base_reg      <= 8'd16;
            phase_reg     <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sweep_reg     <= sweep_next;
            nfp_reg       <= nfp_next;
            res_valid_reg <= res_valid_next;
            base_reg      <= base_next;
            phase_reg     <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg      <= req_next;
        page_reg     <= page_next;
        lvl_reg      <= lvl_next;
        new_page_reg <= new_page_next;
        val_reg      <= val_next;
        written_reg  <= written_next;
        status_reg   <= status_next;
        res_reg      <= res_next;
    end

    // the pool count stays within the pool
    a_pool_bound: assert property (@(posedge clk) disable iff (!rst_n)
        nfp_reg >= CNT_W'(1) && nfp_reg <= CNT_W'(TABLE_PAGES))
        else $error("pool count out of range");

    // pages are allocated only while inspecting a directory entry
    a_alloc_src: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(nfp_reg) |-> $past(state_reg) == ST_CHK)
        else $error("pool count moved outside a walk step");

    // an exhausted pool never reports a written entry
    a_full_nowrite: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && res_reg.status |-> !res_reg.written)
        else $error("exhaustion reported with a write");

endmodule
